>>> rtl/hml_pkg.sv
// Shared types and constants for the heartbeat membership leader.
`timescale 1ns / 1ps
package hml_pkg;
  localparam int MaxPeers = 8;
  localparam int KeyBits = 64;
  localparam int IdxW = $clog2(MaxPeers);
  localparam int CntW = $clog2(MaxPeers + 1);
  localparam int AliveW = $clog2(MaxPeers + 2);

  typedef logic [KeyBits-1:0] key_t;

  typedef enum logic [1:0] {
    FnAdd  = 2'd0,
    FnBeat = 2'd1,
    FnTick = 2'd2,
    FnNop  = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    HAlive   = 2'd0,
    HSuspect = 2'd1,
    HDead    = 2'd2
  } health_e;

  typedef enum logic [2:0] {
    StOk      = 3'd0,
    StFull    = 3'd1,
    StDup     = 3'd2,
    StSelf    = 3'd3,
    StUnknown = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    SIdle  = 3'b001,
    SWalk  = 3'b010,
    SOut   = 3'b100
  } state_e;

  localparam logic [1:0] RegSelf = 2'd0;
  localparam logic [1:0] RegPing = 2'd1;
  localparam logic [1:0] RegSusp = 2'd2;

  // Command broadcast to all cells.
  typedef struct packed {
    logic    add_en;   // write new entry
    logic    beat_en;  // heartbeat to matched entry
    logic    tick_en;  // grade by age
    logic [IdxW-1:0] sel;
    key_t    key;
    logic [31:0] now;
    logic [15:0] susp;
  } cell_cmd_t;

  // Status token passed down the chain.
  typedef struct packed {
    key_t        best;     // running minimum alive id
    logic        hit;      // key matched some earlier cell
    logic [IdxW-1:0] hit_idx;
  } chain_t;

  typedef struct packed {
    logic valid;
    logic alive;
    logic dead;
    logic ring;
    logic was_alive;
    logic chg;
  } cell_stat_t;
endpackage

>>> rtl/hml_if.sv
// Valid/ready channel interfaces for the membership leader.
`timescale 1ns / 1ps
interface hml_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [63:0] peer_key;
  logic [31:0] now_sec;
  modport source(output valid, func, peer_key, now_sec, input ready);
  modport sink(input valid, func, peer_key, now_sec, output ready);
endinterface

interface hml_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [63:0] leader_key;
  logic        self_leads;
  logic [31:0] view_number;
  logic [3:0]  alive_total;
  logic [7:0]  ping_mask;
  logic [7:0]  ring_mask;
  modport source(output valid, status, leader_key, self_leads, view_number,
                 alive_total, ping_mask, ring_mask, input ready);
  modport sink(input valid, status, leader_key, self_leads, view_number,
               alive_total, ping_mask, ring_mask, output ready);
endinterface

>>> rtl/hml_cell.sv
// One peer table entry with match and running-minimum chain logic.
`timescale 1ns / 1ps
module hml_cell (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [hml_pkg::IdxW-1:0] idx_i,
  input  logic                 valid_i,
  input  hml_pkg::cell_cmd_t   cmd_i,
  input  hml_pkg::chain_t      chain_i,
  output hml_pkg::chain_t      chain_o,
  output hml_pkg::cell_stat_t  stat_o
);
  import hml_pkg::*;

  key_t        id_q;
  logic [31:0] seen_t_q;
  logic        seen_q, ring_q;
  health_e     health_q, health_d, grade;
  logic        ring_d;
  logic [31:0] age;
  logic        match;

  assign match = valid_i && (id_q == cmd_i.key);
  assign age = cmd_i.now - seen_t_q;

  always_comb begin
    if (age < {16'd0, cmd_i.susp}) grade = HAlive;
    else if ({1'b0, age} < {16'd0, cmd_i.susp, 1'b0}) grade = HSuspect;
    else grade = HDead;
  end

  always_comb begin
    health_d = health_q;
    ring_d = ring_q;
    if (cmd_i.add_en && cmd_i.sel == idx_i) begin
      health_d = HSuspect;
      ring_d = 1'b1;
    end else if (cmd_i.beat_en && cmd_i.sel == idx_i) begin
      health_d = HAlive;
      ring_d = (health_q != HAlive) ? 1'b1 : ring_q;
    end else if (cmd_i.tick_en && valid_i && seen_q) begin
      health_d = grade;
      if (grade != health_q) begin
        if (health_q == HAlive) ring_d = 1'b0;
        else if (grade == HAlive) ring_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q <= 1'b0;
      ring_q <= 1'b0;
      health_q <= HSuspect;
    end else begin
      health_q <= health_d;
      ring_q <= ring_d;
      if (cmd_i.add_en && cmd_i.sel == idx_i) seen_q <= 1'b0;
      else if (cmd_i.beat_en && cmd_i.sel == idx_i) seen_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.add_en && cmd_i.sel == idx_i) id_q <= cmd_i.key;
    if (cmd_i.beat_en && cmd_i.sel == idx_i) seen_t_q <= cmd_i.now;
  end

  always_comb begin
    chain_o = chain_i;
    if (match && !chain_i.hit) begin
      chain_o.hit = 1'b1;
      chain_o.hit_idx = idx_i;
    end
    if (valid_i && health_q == HAlive && id_q < chain_i.best) chain_o.best = id_q;
  end

  assign stat_o.valid = valid_i;
  assign stat_o.alive = valid_i && health_q == HAlive;
  assign stat_o.dead = health_q == HDead;
  assign stat_o.ring = valid_i && ring_q;
  assign stat_o.was_alive = health_q == HAlive;
  assign stat_o.chg = cmd_i.tick_en && valid_i && seen_q && (grade != health_q);
endmodule

>>> rtl/heartbeat_membership_leader.sv
// Top level: control sequencer, registers and chain of peer cells.
// The walk steps through lookup, update, elect and result register phases from input
// transfer to result valid.
// Input ready stays low until the item is done: the four walk phases, the result
// transfer, and the return to idle, where input ready is raised again.
// Reset: asynchronous active low; table empty, leader equal to self id, view 1.
`timescale 1ns / 1ps
module heartbeat_membership_leader (
  input  logic        clk_i,
  input  logic        rst_ni,
  hml_in_if.sink      in_if,
  hml_out_if.source   out_if,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);
  import hml_pkg::*;

  typedef enum logic [3:0] {
    PLook  = 4'b0001,
    PUpd   = 4'b0010,
    PElect = 4'b0100,
    PDone  = 4'b1000
  } phase_e;

  key_t        self_q;
  logic [15:0] ping_q, susp_q;
  logic [31:0] lping_q, view_q;
  key_t        leader_q;
  logic        lself_q;
  logic [CntW-1:0] total_q;
  state_e      st_q;
  phase_e      ph_q;
  logic [1:0]  func_q;
  key_t        key_q;
  logic [31:0] now_q;
  logic [2:0]  status_q;
  logic [7:0]  pmask_q;
  logic        hit_q, elect_q, changed_q;
  logic [IdxW-1:0] hit_idx_q;

  cell_cmd_t   cmd;
  chain_t      chain [MaxPeers+1];
  cell_stat_t  stat [MaxPeers];
  logic [MaxPeers-1:0] vmask, amask, rmask, nd, cmask;
  logic [AliveW-1:0] alive_cnt;
  logic [1:0]  widx;

  assign pready = 1'b1;
  assign widx = paddr[4:3];
  always_comb begin
    case (widx)
      RegSelf: prdata = self_q;
      RegPing: prdata = {48'd0, ping_q};
      RegSusp: prdata = {48'd0, susp_q};
      default: prdata = 64'd0;
    endcase
  end

  assign chain[0] = {self_q, 1'b0, {IdxW{1'b0}}};

  always_comb begin
    cmd = '0;
    cmd.key = key_q;
    cmd.now = now_q;
    cmd.susp = susp_q;
    cmd.sel = hit_idx_q;
    if (st_q == SWalk && ph_q == PUpd) begin
      case (func_q)
        FnAdd: begin
          cmd.add_en = (total_q < CntW'(MaxPeers)) && !hit_q && key_q != self_q;
          cmd.sel = IdxW'(total_q);
        end
        FnBeat: cmd.beat_en = hit_q;
        FnTick: cmd.tick_en = 1'b1;
        default: ;
      endcase
    end
  end

  for (genvar g = 0; g < MaxPeers; g++) begin : g_cell
    hml_cell u_cell (
      .clk_i, .rst_ni,
      .idx_i(IdxW'(g)),
      .valid_i(CntW'(g) < total_q),
      .cmd_i(cmd),
      .chain_i(chain[g]),
      .chain_o(chain[g+1]),
      .stat_o(stat[g])
    );
    assign vmask[g] = stat[g].valid;
    assign amask[g] = stat[g].alive;
    assign rmask[g] = stat[g].ring;
    assign nd[g] = stat[g].valid && !stat[g].dead;
    assign cmask[g] = stat[g].chg;
  end

  always_comb begin
    alive_cnt = AliveW'(1);
    for (int i = 0; i < MaxPeers; i++) alive_cnt = alive_cnt + AliveW'(amask[i]);
  end

  assign in_if.ready = st_q == SIdle;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      self_q <= '0; ping_q <= 16'd10; susp_q <= 16'd30;
      lping_q <= '0; view_q <= 32'd1; leader_q <= '0; lself_q <= 1'b1;
      total_q <= '0; st_q <= SIdle; ph_q <= PLook;
      out_if.valid <= 1'b0;
    end else begin
      if (psel && penable && pwrite) begin
        case (widx)
          RegSelf: self_q <= pwdata[KeyBits-1:0];
          RegPing: ping_q <= pwdata[15:0];
          RegSusp: susp_q <= pwdata[15:0];
          default: ;
        endcase
      end
      case (st_q)
        SIdle: if (in_if.valid) begin
          st_q <= SWalk; ph_q <= PLook;
        end
        SWalk: begin
          case (ph_q)
            PLook: ph_q <= PUpd;
            PUpd: begin
              if (cmd.add_en) total_q <= total_q + CntW'(1);
              if (func_q == FnTick && (now_q - lping_q) >= {16'd0, ping_q})
                lping_q <= now_q;
              ph_q <= PElect;
            end
            PElect: begin
              if (elect_q || changed_q) begin
                if (chain[MaxPeers].best != leader_q) view_q <= view_q + 32'd1;
                leader_q <= chain[MaxPeers].best;
                lself_q <= chain[MaxPeers].best == self_q;
              end
              ph_q <= PDone;
            end
            default: begin
              st_q <= SOut;
              out_if.valid <= 1'b1;
            end
          endcase
        end
        SOut: if (out_if.ready) begin
          out_if.valid <= 1'b0; st_q <= SIdle;
        end
        default: st_q <= SIdle;
      endcase
    end
  end

  // Payload capture, lookup results and election flags
  always_ff @(posedge clk_i) begin
    if (st_q == SIdle && in_if.valid) begin
      func_q <= in_if.func; key_q <= in_if.peer_key[KeyBits-1:0];
      now_q <= in_if.now_sec;
    end
    if (st_q == SWalk && ph_q == PLook) begin
      hit_q <= chain[MaxPeers].hit;
      hit_idx_q <= chain[MaxPeers].hit_idx;
      status_q <= StOk;
      pmask_q <= '0;
      case (func_q)
        FnAdd: if (total_q >= CntW'(MaxPeers)) status_q <= StFull;
          else if (chain[MaxPeers].hit) status_q <= StDup;
          else if (key_q == self_q) status_q <= StSelf;
        FnBeat: if (!chain[MaxPeers].hit) status_q <= StUnknown;
        FnTick: if ((now_q - lping_q) >= {16'd0, ping_q}) pmask_q <= nd;
        default: ;
      endcase
    end
    if (st_q == SWalk && ph_q == PUpd) begin
      elect_q <= cmd.add_en ||
                 (cmd.beat_en && !stat[hit_idx_q].was_alive);
      changed_q <= |cmask;
    end
  end

  assign out_if.status = status_q;
  assign out_if.leader_key = 64'(leader_q);
  assign out_if.self_leads = lself_q;
  assign out_if.view_number = view_q;
  assign out_if.alive_total = 4'(alive_cnt);
  assign out_if.ping_mask = 8'(pmask_q);
  assign out_if.ring_mask = 8'(rmask & vmask);
endmodule
